[hw/rtl/base64_stream_decoder_macros.svh]
// Assertion macros for the base64 stream decoder.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef BASE64_STREAM_DECODER_MACROS_SVH
`define BASE64_STREAM_DECODER_MACROS_SVH
`ifndef ASSERT_OFF
`define B64D_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("b64d assertion failed");
`define B64D_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("b64d assertion failed");
`else
`define B64D_ASSERT(label, clk, rst, prop)
`define B64D_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[hw/rtl/b64d_pkg.sv]
// Shared constants, result group type and character decode for the base64 decoder.
// No dependencies.
package b64d_pkg;

  localparam int CharW   = 16;
  localparam int SextetW = 6;
  localparam int WordW   = 24;
  localparam int CountW  = 32;

  localparam logic       KIND_DATA = 1'b0;
  localparam logic       KIND_END  = 1'b1;

  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_BAD_LENGTH = 2'd1;
  localparam logic [1:0] STATUS_BAD_CHAR   = 2'd2;

  localparam logic [CharW-1:0] CHAR_UPPER_A = 16'h0041;
  localparam logic [CharW-1:0] CHAR_UPPER_Z = 16'h005A;
  localparam logic [CharW-1:0] CHAR_LOWER_A = 16'h0061;
  localparam logic [CharW-1:0] CHAR_LOWER_Z = 16'h007A;
  localparam logic [CharW-1:0] CHAR_DIGIT_0 = 16'h0030;
  localparam logic [CharW-1:0] CHAR_DIGIT_9 = 16'h0039;
  localparam logic [CharW-1:0] CHAR_PLUS    = 16'h002B;
  localparam logic [CharW-1:0] CHAR_SLASH   = 16'h002F;
  localparam logic [CharW-1:0] CHAR_PAD     = 16'h003D;

  localparam logic [SextetW-1:0] SEXTET_PLUS  = 6'd62;
  localparam logic [SextetW-1:0] SEXTET_SLASH = 6'd63;

  typedef struct packed {
    logic [1:0]        nbytes;
    logic              has_end;
    logic [1:0]        status;
    logic [CountW-1:0] count;
    logic [WordW-1:0]  word;
  } group_t;

  typedef struct packed {
    logic               invalid;
    logic [SextetW-1:0] sextet;
  } sextet_t;

  function automatic sextet_t decode_char(input logic [CharW-1:0] c);
    sextet_t r;
    r.invalid = 1'b1;
    r.sextet  = '0;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      r.invalid = 1'b0;
      r.sextet  = SextetW'(c - CHAR_UPPER_A);
    end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      r.invalid = 1'b0;
      r.sextet  = SextetW'(c - CHAR_LOWER_A + 16'd26);
    end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
      r.invalid = 1'b0;
      r.sextet  = SextetW'(c - CHAR_DIGIT_0 + 16'd52);
    end else if (c == CHAR_PLUS) begin
      r.invalid = 1'b0;
      r.sextet  = SEXTET_PLUS;
    end else if (c == CHAR_SLASH) begin
      r.invalid = 1'b0;
      r.sextet  = SEXTET_SLASH;
    end else if (c == CHAR_PAD) begin
      r.invalid = 1'b0;
      r.sextet  = '0;
    end
    return r;
  endfunction

endpackage

[hw/rtl/b64d_core.sv]
// Stream state and per-character decode; registers one result group per completed quartet or error.
// Depends on b64d_pkg.
module b64d_core
  import b64d_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [CharW-1:0] in_char,
  input  logic             in_final,
  output group_t           grp,
  output logic             grp_valid,
  input  logic             grp_take
);

  logic [17:0]       sextet_buffer, sextet_buffer_next;
  logic [1:0]        quartet_position, quartet_position_next;
  logic [1:0]        pad_flags, pad_flags_next;
  logic [CountW-1:0] bytes_emitted, bytes_emitted_next;
  logic              error_seen, error_seen_next;

  group_t            grp_next;
  logic              emit;
  logic              accept;
  sextet_t           dec;
  logic              is_pad;
  logic [CountW:0]   sum;

  assign in_ready = !grp_valid || grp_take;
  assign accept   = in_valid && in_ready;
  assign dec      = decode_char(in_char);
  assign is_pad   = (in_char == CHAR_PAD);

  always_comb begin
    sextet_buffer_next    = sextet_buffer;
    quartet_position_next = quartet_position;
    pad_flags_next        = pad_flags;
    bytes_emitted_next    = bytes_emitted;
    error_seen_next       = error_seen;
    emit                  = 1'b0;
    grp_next.nbytes       = 2'd0;
    grp_next.has_end      = 1'b0;
    grp_next.status       = STATUS_OK;
    grp_next.count        = bytes_emitted;
    grp_next.word         = {sextet_buffer, dec.sextet};
    sum                   = '0;
    if (error_seen) begin
      // drop until the final character
    end else if (dec.invalid) begin
      emit             = 1'b1;
      grp_next.has_end = 1'b1;
      grp_next.status  = STATUS_BAD_CHAR;
      error_seen_next  = 1'b1;
    end else if (quartet_position != 2'd3) begin
      sextet_buffer_next    = {sextet_buffer[11:0], dec.sextet};
      quartet_position_next = quartet_position + 2'd1;
      pad_flags_next        = {pad_flags[0], is_pad};
      if (in_final) begin
        emit             = 1'b1;
        grp_next.has_end = 1'b1;
        grp_next.status  = STATUS_BAD_LENGTH;
      end
    end else begin
      emit            = 1'b1;
      grp_next.nbytes = 2'd3;
      if (in_final && is_pad) begin
        grp_next.nbytes = pad_flags[0] ? 2'd1 : 2'd2;
      end
      sum                   = {1'b0, bytes_emitted} + (CountW+1)'(grp_next.nbytes);
      bytes_emitted_next    = sum[CountW] ? '1 : sum[CountW-1:0];
      grp_next.count        = bytes_emitted_next;
      grp_next.has_end      = in_final;
      sextet_buffer_next    = '0;
      quartet_position_next = 2'd0;
      pad_flags_next        = {pad_flags[0], is_pad};
    end
    if (in_final) begin
      sextet_buffer_next    = '0;
      quartet_position_next = 2'd0;
      pad_flags_next        = 2'd0;
      bytes_emitted_next    = '0;
      error_seen_next       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sextet_buffer    <= '0;
      quartet_position <= '0;
      pad_flags        <= '0;
      bytes_emitted    <= '0;
      error_seen       <= 1'b0;
      grp_valid        <= 1'b0;
    end else begin
      if (accept) begin
        sextet_buffer    <= sextet_buffer_next;
        quartet_position <= quartet_position_next;
        pad_flags        <= pad_flags_next;
        bytes_emitted    <= bytes_emitted_next;
        error_seen       <= error_seen_next;
      end
      if (accept && emit) begin
        grp_valid <= 1'b1;
      end else if (grp_take) begin
        grp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      grp <= grp_next;
    end
  end

endmodule

[hw/rtl/b64d_serializer.sv]
// Holds one result group and sends its words out one per cycle while out_ready is high.
// Depends on b64d_pkg.
module b64d_serializer
  import b64d_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  group_t            grp,
  input  logic              grp_valid,
  output logic              grp_take,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              kind,
  output logic [7:0]        data_byte,
  output logic [1:0]        status,
  output logic [CountW-1:0] byte_count,
  output logic              run_last
);

  group_t     cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic [2:0] total;
  logic       fire;
  logic       is_data;

  assign total     = {1'b0, cur.nbytes} + {2'b0, cur.has_end};
  assign run_last  = ({1'b0, idx} == total - 3'd1);
  assign out_valid = cur_valid;
  assign fire      = cur_valid && out_ready;
  assign grp_take  = grp_valid && (!cur_valid || (fire && run_last));
  assign is_data   = (idx < cur.nbytes);
  assign kind      = is_data ? KIND_DATA : KIND_END;

  always_comb begin
    data_byte  = '0;
    status     = STATUS_OK;
    byte_count = '0;
    if (is_data) begin
      case (idx)
        2'd0:    data_byte = cur.word[23:16];
        2'd1:    data_byte = cur.word[15:8];
        default: data_byte = cur.word[7:0];
      endcase
    end else begin
      status     = cur.status;
      byte_count = cur.count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (grp_take) begin
        cur_valid <= 1'b1;
        idx       <= '0;
      end else if (fire && run_last) begin
        cur_valid <= 1'b0;
        idx       <= '0;
      end else if (fire) begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (grp_take) begin
      cur <= grp;
    end
  end

endmodule

[hw/rtl/base64_stream_decoder.sv]
// Top level of the streaming base64 decoder.
// Depends on b64d_pkg, b64d_core, b64d_serializer and base64_stream_decoder_macros.svh.
//
// Takes one UTF-16 character per cycle on the s_axis side (tlast marks the final
// character) and returns decoded bytes and one end-of-stream status word on the
// m_axis side. A character is accepted in every cycle as long as the output keeps
// up; results leave at one word per cycle while m_axis_tready is high, a completed
// quartet gives up to three data words (and an end word when it is the final
// one), and the input stalls once two result groups are waiting. The byte count
// saturates at all ones.
`include "base64_stream_decoder_macros.svh"
module base64_stream_decoder
  import b64d_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] char_code
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [7:0] data_byte, [9:8] status, [41:10] byte_count
  output logic        m_axis_tuser,   // [0] kind
  output logic        m_axis_tlast
);

  group_t            grp;
  logic              grp_valid;
  logic              grp_take;
  logic              kind;
  logic [7:0]        data_byte;
  logic [1:0]        status;
  logic [CountW-1:0] byte_count;
  logic              run_last;

  b64d_core u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_char   (s_axis_tdata),
    .in_final  (s_axis_tlast),
    .grp       (grp),
    .grp_valid (grp_valid),
    .grp_take  (grp_take)
  );

  b64d_serializer u_serializer (
    .clk        (clk),
    .rst        (rst),
    .grp        (grp),
    .grp_valid  (grp_valid),
    .grp_take   (grp_take),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .kind       (kind),
    .data_byte  (data_byte),
    .status     (status),
    .byte_count (byte_count),
    .run_last   (run_last)
  );

  assign m_axis_tdata = {6'b0, byte_count, status, data_byte};
  assign m_axis_tuser = kind;
  assign m_axis_tlast = run_last;

  `B64D_ASSERT(a_end_is_last, clk, rst, (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
  `B64D_ASSERT(a_data_fields_clear, clk, rst, (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[41:8] == 34'd0))
  `B64D_ASSERT(a_status_legal, clk, rst, (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[9:8] != 2'd3))
  `B64D_ASSERT_NEXT(a_group_handoff, clk, rst, (grp_valid && !grp_take), grp_valid)

endmodule

[tb/sv/b64_decode_checker.sv]
// Result checker for the base64 stream decoder: predicts decoded bytes and end words.
// Watches both stream channels of the decoder; depends on b64d_pkg.
`timescale 1ns / 100ps
module b64_decode_checker
  import b64d_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata,
  input  logic        m_axis_tuser,
  input  logic        m_axis_tlast,
  output int          results_due,
  output int          mismatch_count
);

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [1:0]  status;
    logic [31:0] byte_count;
    logic        run_last;
  } dec_result_t;

  dec_result_t expected_results[$];

  logic [17:0] quartet_bits;
  logic [1:0]  quartet_fill;
  logic [1:0]  pad_history;
  logic [31:0] bytes_out;
  logic        dropping;
  int          fail_total = 0;

  function automatic logic [6:0] lookup_sextet(input logic [15:0] c);
    logic [15:0] d;
    logic        ok;
    ok = 1'b1;
    d  = '0;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      d = c - CHAR_UPPER_A;
    end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      d = c - CHAR_LOWER_A + 16'd26;
    end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
      d = c - CHAR_DIGIT_0 + 16'd52;
    end else if (c == CHAR_PLUS) begin
      d = {10'd0, SEXTET_PLUS};
    end else if (c == CHAR_SLASH) begin
      d = {10'd0, SEXTET_SLASH};
    end else if (c != CHAR_PAD) begin
      ok = 1'b0;
    end
    return {ok, d[5:0]};
  endfunction

  task automatic clear_stream();
    quartet_bits = '0;
    quartet_fill = '0;
    pad_history  = '0;
    bytes_out    = '0;
    dropping     = 1'b0;
  endtask

  task automatic add_result(input logic kind, input logic [7:0] data, input logic [1:0] st,
                            input logic [31:0] cnt, input logic last);
    dec_result_t r;
    r.kind       = kind;
    r.data_byte  = data;
    r.status     = st;
    r.byte_count = cnt;
    r.run_last   = last;
    expected_results.push_back(r);
  endtask

  task automatic predict_char(input logic [15:0] c, input logic fin);
    logic [6:0]  lk;
    logic [23:0] group_bits;
    logic        is_pad;
    int          nbytes;
    int          i;
    if (dropping) begin
      if (fin) clear_stream();
    end else begin
      lk     = lookup_sextet(c);
      is_pad = (c == CHAR_PAD);
      if (!lk[6]) begin
        add_result(KIND_END, 8'h00, STATUS_BAD_CHAR, bytes_out, 1'b1);
        dropping = 1'b1;
        if (fin) clear_stream();
      end else if (quartet_fill != 2'd3) begin
        quartet_bits = {quartet_bits[11:0], lk[5:0]};
        quartet_fill = quartet_fill + 2'd1;
        pad_history  = {pad_history[0], is_pad};
        if (fin) begin
          add_result(KIND_END, 8'h00, STATUS_BAD_LENGTH, bytes_out, 1'b1);
          clear_stream();
        end
      end else begin
        group_bits = {quartet_bits, lk[5:0]};
        nbytes = 3;
        if (fin && is_pad) nbytes = pad_history[0] ? 1 : 2;
        for (i = 0; i < nbytes; i++) begin
          add_result(KIND_DATA, group_bits[23 - 8 * i -: 8], STATUS_OK, 32'd0,
                     !fin && (i == nbytes - 1));
          if (bytes_out != '1) bytes_out = bytes_out + 32'd1;
        end
        quartet_bits = '0;
        quartet_fill = '0;
        pad_history  = {pad_history[0], is_pad};
        if (fin) begin
          add_result(KIND_END, 8'h00, STATUS_OK, bytes_out, 1'b1);
          clear_stream();
        end
      end
    end
  endtask

  task automatic check_result();
    dec_result_t want;
    logic [47:0] want_data;
    if (expected_results.size() == 0) begin
      fail_total++;
      if (fail_total <= 10)
        $display("%0t: unexpected word kind %0d tdata %h last %0d",
                 $time, m_axis_tuser, m_axis_tdata, m_axis_tlast);
    end else begin
      want      = expected_results.pop_front();
      want_data = {6'd0, want.byte_count, want.status, want.data_byte};
      if (m_axis_tuser !== want.kind || m_axis_tdata !== want_data ||
          m_axis_tlast !== want.run_last) begin
        fail_total++;
        if (fail_total <= 10) begin
          $display("%0t: word mismatch: expected kind %0d byte %h status %0d count %0d last %0d",
                   $time, want.kind, want.data_byte, want.status, want.byte_count,
                   want.run_last);
          $display("  got kind %0d byte %h status %0d count %0d last %0d pad %h",
                   m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[9:8],
                   m_axis_tdata[41:10], m_axis_tlast, m_axis_tdata[47:42]);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_stream();
      expected_results.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) predict_char(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) check_result();
    end
    results_due    <= expected_results.size();
    mismatch_count <= fail_total;
  end

endmodule

[tb/sv/tb.sv]
// Testbench top for the base64 stream decoder: clock, reset, text stimulus and verdict.
// Depends on b64d_pkg, base64_stream_decoder and b64_decode_checker.
`timescale 1ns / 100ps
module tb;
  import b64d_pkg::*;

  localparam int ITEMS_TARGET = 470;
  localparam int HOLD_CYCLES  = 64;
  localparam int STALL_LIMIT  = 2000;

  typedef enum int {SINK_OPEN, SINK_COIN, SINK_MOSTLY, SINK_EVERY_THIRD} sink_mode_e;
  typedef enum int {TEXT_CLEAN, TEXT_SHORT, TEXT_BAD_CHAR, TEXT_NOISE} text_shape_e;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  int          results_due;
  int          mismatch_count;
  int          items_sent = 0;
  int          burst_left = 0;
  bit          hold_request = 1'b0;
  logic [15:0] text_q[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  base64_stream_decoder u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  b64_decode_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tlast   (s_axis_tlast),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tuser   (m_axis_tuser),
    .m_axis_tlast   (m_axis_tlast),
    .results_due    (results_due),
    .mismatch_count (mismatch_count)
  );

  function automatic bit is_b64(input logic [15:0] c);
    return (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ||
           (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) ||
           (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) || c == CHAR_PLUS || c == CHAR_SLASH ||
           c == CHAR_PAD;
  endfunction

  function automatic logic [15:0] random_alpha();
    logic [15:0] s;
    s = 16'($urandom_range(0, 63));
    if (s < 16'd26) return CHAR_UPPER_A + s;
    if (s < 16'd52) return CHAR_LOWER_A + s - 16'd26;
    if (s < 16'd62) return CHAR_DIGIT_0 + s - 16'd52;
    if (s == 16'd62) return CHAR_PLUS;
    return CHAR_SLASH;
  endfunction

  function automatic logic [15:0] bad_char();
    logic [15:0] c;
    case ($urandom_range(0, 2))
      0: c = 16'($urandom_range(128, 65535));
      1: c = 16'($urandom_range(123, 127));
      default: begin
        c = 16'($urandom_range(0, 127));
        while (is_b64(c)) c = 16'($urandom_range(0, 127));
      end
    endcase
    return c;
  endfunction

  task automatic send_char(input logic [15:0] c, input logic fin, input bit counts);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 60 : 8);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= fin;
    do @(posedge clk); while (!s_axis_tready);
    burst_left--;
    if (counts) items_sent++;
  endtask

  task automatic send_text();
    int i;
    bit live;
    live = 1'b1;
    for (i = 0; i < text_q.size(); i++) begin
      send_char(text_q[i], i == text_q.size() - 1, live);
      if (!is_b64(text_q[i])) live = 1'b0;
    end
    text_q.delete();
  endtask

  task automatic add_ascii(input string s);
    int i;
    for (i = 0; i < s.len(); i++) text_q.push_back({8'h00, s[i]});
  endtask

  task automatic build_clean(input int quartets, input int pads);
    int i;
    for (i = 0; i < 4 * quartets + 4; i++)
      text_q.push_back(($urandom_range(0, 9) == 0) ? CHAR_PAD : random_alpha());
    for (i = 0; i < pads; i++) text_q[text_q.size() - 1 - i] = CHAR_PAD;
  endtask

  task automatic wait_all_results();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (results_due != 0);
  endtask

  initial begin : sink
    sink_mode_e mode;
    int span;
    int k;
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        mode = sink_mode_e'($urandom_range(0, 3));
        span = $urandom_range(16, 120);
        for (k = 0; k < span && !hold_request; k++) begin
          case (mode)
            SINK_OPEN:        m_axis_tready <= 1'b1;
            SINK_COIN:        m_axis_tready <= 1'($urandom_range(0, 1));
            SINK_MOSTLY:      m_axis_tready <= ($urandom_range(0, 3) != 0);
            SINK_EVERY_THIRD: m_axis_tready <= (k % 3 == 0);
            default:          m_axis_tready <= 1'b1;
          endcase
          @(posedge clk);
        end
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle = 0;
      else
        idle++;
    end
    $display("[base64_stream_decoder] ERROR");
    $finish;
  end

  initial begin : stimulus
    text_shape_e shape;
    int nq;
    int pick;
    int n;
    int i;
    int streams;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    add_ascii("+/9zTWE=");
    send_text();
    add_ascii("A=B=TQ==");
    send_text();
    add_ascii("TW");
    send_text();
    add_ascii("Zm");
    text_q.push_back(16'hFFFF);
    text_q.push_back(16'h0000);
    add_ascii("0");
    send_text();
    text_q.push_back(16'h007B);
    send_text();

    streams = 0;
    while (items_sent < ITEMS_TARGET) begin
      streams++;
      nq   = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 10) : $urandom_range(0, 3);
      pick = $urandom_range(0, 19);
      if (pick < 12)      shape = TEXT_CLEAN;
      else if (pick < 15) shape = TEXT_SHORT;
      else if (pick < 18) shape = TEXT_BAD_CHAR;
      else                shape = TEXT_NOISE;
      if (streams == 6) begin
        hold_request = 1'b1;
        nq    = 10;
        shape = TEXT_CLEAN;
      end
      if (streams == 25) wait_all_results();
      case (shape)
        TEXT_CLEAN: build_clean(nq, $urandom_range(0, 2));
        TEXT_SHORT: begin
          build_clean(nq, $urandom_range(0, 2));
          repeat ($urandom_range(1, 3)) void'(text_q.pop_back());
        end
        TEXT_BAD_CHAR: begin
          build_clean(nq, $urandom_range(0, 2));
          text_q[$urandom_range(0, text_q.size() - 1)] = bad_char();
        end
        default: begin
          n = $urandom_range(1, 6);
          for (i = 0; i < n; i++) begin
            case ($urandom_range(0, 2))
              0:       text_q.push_back(16'($urandom_range(0, 65535)));
              1:       text_q.push_back(random_alpha());
              default: text_q.push_back(CHAR_PAD);
            endcase
          end
        end
      endcase
      send_text();
    end

    wait_all_results();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[base64_stream_decoder] OK");
    end else begin
      $display("[base64_stream_decoder] ERROR");
    end
    $finish;
  end

endmodule
